@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VARM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define VARM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/varm_pkg.sv @@
package varm_pkg;

    localparam int IN_W      = 32;
    localparam int OUT_W     = 18;
    localparam int UNIT_BITS = 30;
    localparam int C_W       = 34;   // cross, cosine and 1+cos in Q2.30
    localparam int NRM_QW    = 31;   // unit component magnitude bits
    localparam int RQ_QW     = 41;   // quadratic term quotient bits (saturating)

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;
    localparam logic signed [C_W-1:0]   ONE_Q   = 34'sd1073741824;

    typedef logic signed [IN_W-1:0]  comp_t;
    typedef logic signed [C_W-1:0]   cq_t;
    typedef logic signed [OUT_W-1:0] entry_t;

    function automatic logic signed [63:0] mul32(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        logic signed [63:0] p;
        p = x * y;
        return p;
    endfunction

    function automatic logic signed [67:0] mul34(input logic signed [33:0] x,
                                                 input logic signed [33:0] y);
        logic signed [67:0] p;
        p = x * y;
        return p;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Right shift, round to nearest with ties away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic signed [63:0] half;
        logic signed [63:0] adj;
        half = 64'sd1 <<< (sh - 1);
        adj  = v[63] ? half - 64'sd1 : half;
        if (sh == 0) begin
            return v;
        end
        return (v + adj) >>> sh;
    endfunction

    function automatic entry_t sat_out(input logic signed [63:0] v);
        if (v > 64'(OUT_MAX)) begin
            return OUT_MAX;
        end
        if (v < 64'(OUT_MIN)) begin
            return OUT_MIN;
        end
        return entry_t'(v);
    endfunction

endpackage

@@ rtl/core/varm_isqrt.sv @@
module varm_isqrt #(
    parameter int LANES = 2,
    parameter int W     = 64,
    parameter int SW    = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [LANES-1:0][W-1:0]       rad,
    input  logic [SW-1:0]                 sb_in,
    output logic                          out_valid,
    output logic [LANES-1:0][W/2-1:0]     root,
    output logic [SW-1:0]                 sb_out
);

    localparam int STEPS = W / 2;

    logic          v_reg  [STEPS+1];
    logic [SW-1:0] sb_reg [STEPS+1];
    logic [W-1:0]  n_reg  [STEPS+1][LANES];
    logic [W-1:0]  r_reg  [STEPS+1][LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= sb_in;
            for (int l = 0; l < LANES; l++) begin
                n_reg[0][l] <= rad[l];
                r_reg[0][l] <= '0;
            end
        end
    end

    // One result bit per stage, two radicand bits consumed.
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 * k);
        logic [W-1:0] trial [LANES];
        logic         take  [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = r_reg[k-1][l] + BIT;
                take[l]  = n_reg[k-1][l] >= trial[l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sb_reg[k] <= sb_reg[k-1];
                for (int l = 0; l < LANES; l++) begin
                    n_reg[k][l] <= take[l] ? n_reg[k-1][l] - trial[l] : n_reg[k-1][l];
                    r_reg[k][l] <= take[l] ? (r_reg[k-1][l] >> 1) + BIT
                                           : r_reg[k-1][l] >> 1;
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            root[l] = r_reg[STEPS][l][W/2-1:0];
        end
    end

    assign out_valid = v_reg[STEPS];
    assign sb_out    = sb_reg[STEPS];

endmodule

@@ rtl/core/varm_div.sv @@
module varm_div #(
    parameter int LANES = 6,
    parameter int NW    = 62,
    parameter int DW    = 32,
    parameter int QW    = 31,
    parameter int SW    = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [LANES-1:0][NW-1:0]  num,
    input  logic [LANES-1:0][DW-1:0]  den,
    input  logic [SW-1:0]             sb_in,
    output logic                      out_valid,
    output logic [LANES-1:0][QW-1:0]  quo,
    output logic [SW-1:0]             sb_out
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic          v_reg   [QW+1];
    logic [SW-1:0] sb_reg  [QW+1];
    logic [RW-1:0] rem_reg [QW+1][LANES];
    logic [DW-1:0] den_reg [QW+1][LANES];
    logic [QW-1:0] q_reg   [QW+1][LANES];
    logic          ovf_reg [QW+1][LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    // Entry: flag quotients that do not fit in QW bits; they saturate.
    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= sb_in;
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= RW'(num[l]);
                den_reg[0][l] <= den[l];
                q_reg[0][l]   <= '0;
                ovf_reg[0][l] <= (RW'(num[l]) >> QW) >= RW'(den[l]);
            end
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [RW-1:0] dsh [LANES];
        logic          ge  [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                dsh[l] = RW'(den_reg[k-1][l]) << (QW - k);
                ge[l]  = rem_reg[k-1][l] >= dsh[l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sb_reg[k] <= sb_reg[k-1];
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k][l] <= ge[l] ? rem_reg[k-1][l] - dsh[l] : rem_reg[k-1][l];
                    den_reg[k][l] <= den_reg[k-1][l];
                    q_reg[k][l]   <= {q_reg[k-1][l][QW-2:0], ge[l]};
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quo[l] = ovf_reg[QW][l] ? {QW{1'b1}} : q_reg[QW][l];
        end
    end

    assign out_valid = v_reg[QW];
    assign sb_out    = sb_reg[QW];

endmodule

@@ rtl/core/varm_outbuf.sv @@
module varm_outbuf #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    output logic              in_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_data
);

    logic              out_v_reg, out_v_next;
    logic              skid_v_reg, skid_v_next;
    logic [DATA_W-1:0] out_d_reg;
    logic [DATA_W-1:0] skid_d_reg;
    logic              load_out, load_skid, from_skid;

    assign in_ready = !skid_v_reg;

    always_comb begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        load_out    = 1'b0;
        load_skid   = 1'b0;
        from_skid   = 1'b0;
        if (skid_v_reg) begin
            if (m_tready) begin
                from_skid   = 1'b1;
                skid_v_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_v_reg || m_tready) begin
                load_out   = 1'b1;
                out_v_next = 1'b1;
            end else begin
                load_skid   = 1'b1;
                skid_v_next = 1'b1;
            end
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (from_skid) begin
            out_d_reg <= skid_d_reg;
        end else if (load_out) begin
            out_d_reg <= in_data;
        end
        if (load_skid) begin
            skid_d_reg <= in_data;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_data   = out_d_reg;

endmodule

@@ rtl/core/vector_align_rotation_matrix_top.sv @@
// Channel   Direction  Payload
// s_        in         tdata: first_x, first_y, first_z, second_x, second_y, second_z
// m_        out        tdata: m00..m22 (Q2.OUT_FRAC_BITS); tuser: degenerate
//
// One vector pair is taken per clock while s_tready is high. The 32-step square root
// and the two 31- and 41-step long dividers run as fully pipelined units.
// aresetn is synchronous, active low, and clears only valid bits and handshake state.
// A stall on m_ freezes the whole pipeline once the skid stage holds an item; until
// then input items keep flowing in while a finished result waits.
`include "assert_macros.svh"

module vector_align_rotation_matrix_top #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // first_x, first_y, first_z, second_x, second_y, second_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad
    output logic [0:0]   m_tuser    // degenerate
);

    localparam int SH = varm_pkg::UNIT_BITS - OUT_FRAC_BITS;
    localparam logic signed [17:0] DIAG =
        (OUT_FRAC_BITS >= 17) ? 18'sd131071 : 18'(1 << OUT_FRAC_BITS);
    localparam int CW    = varm_pkg::C_W;
    localparam int SB1_W = 6 * 32 + 1;
    localparam int SB2_W = 1 + 6 + 4 * CW;
    localparam int RW    = CW + 9;             // sum of a term and a quotient
    localparam int QSW   = varm_pkg::RQ_QW + 1;
    localparam int OB_W  = 9 * 18 + 1;

    logic en;

    // ---------------- stage 1: capture the input item
    logic             v1_reg;
    varm_pkg::comp_t  a1_reg [3];
    varm_pkg::comp_t  b1_reg [3];

    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a1_reg[i] <= s_tdata[32*i +: 32];
                b1_reg[i] <= s_tdata[96+32*i +: 32];
            end
        end
    end

    // ---------------- stage 2: squares and the exact collinearity products
    logic               v2_reg;
    logic signed [63:0] sq2_reg [6];
    logic signed [63:0] cp2_reg [6];
    varm_pkg::comp_t    a2_reg [3];
    varm_pkg::comp_t    b2_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq2_reg[i]   <= varm_pkg::mul32(a1_reg[i], a1_reg[i]);
                sq2_reg[3+i] <= varm_pkg::mul32(b1_reg[i], b1_reg[i]);
                a2_reg[i]    <= a1_reg[i];
                b2_reg[i]    <= b1_reg[i];
            end
            cp2_reg[0] <= varm_pkg::mul32(a1_reg[1], b1_reg[2]);
            cp2_reg[1] <= varm_pkg::mul32(a1_reg[2], b1_reg[1]);
            cp2_reg[2] <= varm_pkg::mul32(a1_reg[2], b1_reg[0]);
            cp2_reg[3] <= varm_pkg::mul32(a1_reg[0], b1_reg[2]);
            cp2_reg[4] <= varm_pkg::mul32(a1_reg[0], b1_reg[1]);
            cp2_reg[5] <= varm_pkg::mul32(a1_reg[1], b1_reg[0]);
        end
    end

    // ---------------- stage 3: squared norms, parallel test
    logic            v3_reg;
    logic [63:0]     nsq3_reg [2];
    logic            par3_reg;
    varm_pkg::comp_t a3_reg [3];
    varm_pkg::comp_t b3_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nsq3_reg[0] <= 64'(sq2_reg[0]) + 64'(sq2_reg[1]) + 64'(sq2_reg[2]);
            nsq3_reg[1] <= 64'(sq2_reg[3]) + 64'(sq2_reg[4]) + 64'(sq2_reg[5]);
            par3_reg    <= (cp2_reg[0] == cp2_reg[1]) && (cp2_reg[2] == cp2_reg[3]) &&
                           (cp2_reg[4] == cp2_reg[5]);
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
        end
    end

    // ---------------- square roots of both norms
    logic [1:0][63:0]  rad;
    logic [SB1_W-1:0]  sb1_in, sb1_out;
    logic              sq_valid;
    logic [1:0][31:0]  root;

    always_comb begin
        rad[0] = nsq3_reg[0];
        rad[1] = nsq3_reg[1];
        for (int i = 0; i < 3; i++) begin
            sb1_in[32*i +: 32]    = a3_reg[i];
            sb1_in[96+32*i +: 32] = b3_reg[i];
        end
        sb1_in[SB1_W-1] = par3_reg;
    end

    varm_isqrt #(.LANES(2), .W(64), .SW(SB1_W)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v3_reg),
        .rad      (rad),
        .sb_in    (sb1_in),
        .out_valid(sq_valid),
        .root     (root),
        .sb_out   (sb1_out)
    );

    // ---------------- stage 4: degenerate check, normalize numerators
    logic        v4_reg;
    logic        dg4_reg;
    logic [61:0] num4_reg [6];
    logic [31:0] den4_reg [6];
    logic        sg4_reg  [6];
    logic signed [31:0] comp4 [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            comp4[i] = sb1_out[32*i +: 32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg4_reg <= (root[0] == '0) || (root[1] == '0) || sb1_out[SB1_W-1];
            for (int i = 0; i < 6; i++) begin
                num4_reg[i] <= (62'(varm_pkg::abs32(comp4[i])) << varm_pkg::UNIT_BITS) +
                               62'(root[i/3] >> 1);
                den4_reg[i] <= root[i/3];
                sg4_reg[i]  <= comp4[i][31];
            end
        end
    end

    // ---------------- unit vectors, rounded division by the norm
    logic [5:0][61:0] num1;
    logic [5:0][31:0] den1;
    logic [6:0]       sbn_in, sbn_out;
    logic             dv1_valid;
    logic [5:0][varm_pkg::NRM_QW-1:0] q1;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            num1[i]   = num4_reg[i];
            den1[i]   = den4_reg[i];
            sbn_in[i] = sg4_reg[i];
        end
        sbn_in[6] = dg4_reg;
    end

    varm_div #(.LANES(6), .NW(62), .DW(32), .QW(varm_pkg::NRM_QW), .SW(7)) u_div_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .num      (num1),
        .den      (den1),
        .sb_in    (sbn_in),
        .out_valid(dv1_valid),
        .quo      (q1),
        .sb_out   (sbn_out)
    );

    // ---------------- stage 5: signed unit components (u: 0..2, w: 3..5)
    logic            v5_reg;
    logic            dg5_reg;
    varm_pkg::comp_t uw5_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= dv1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg5_reg <= sbn_out[6];
            for (int i = 0; i < 6; i++) begin
                uw5_reg[i] <= sbn_out[i] ? -$signed({1'b0, q1[i]}) : $signed({1'b0, q1[i]});
            end
        end
    end

    // ---------------- stage 6: cross and dot partial products
    logic               v6_reg;
    logic               dg6_reg;
    logic signed [63:0] pr6_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg6_reg    <= dg5_reg;
            pr6_reg[0] <= varm_pkg::mul32(uw5_reg[1], uw5_reg[5]);
            pr6_reg[1] <= varm_pkg::mul32(uw5_reg[2], uw5_reg[4]);
            pr6_reg[2] <= varm_pkg::mul32(uw5_reg[2], uw5_reg[3]);
            pr6_reg[3] <= varm_pkg::mul32(uw5_reg[0], uw5_reg[5]);
            pr6_reg[4] <= varm_pkg::mul32(uw5_reg[0], uw5_reg[4]);
            pr6_reg[5] <= varm_pkg::mul32(uw5_reg[1], uw5_reg[3]);
            for (int i = 0; i < 3; i++) begin
                pr6_reg[6+i] <= varm_pkg::mul32(uw5_reg[i], uw5_reg[3+i]);
            end
        end
    end

    // ---------------- stage 7: sums
    logic               v7_reg;
    logic               dg7_reg;
    logic signed [63:0] cr7_reg [3];
    logic signed [63:0] dot7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg7_reg    <= dg6_reg;
            cr7_reg[0] <= pr6_reg[0] - pr6_reg[1];
            cr7_reg[1] <= pr6_reg[2] - pr6_reg[3];
            cr7_reg[2] <= pr6_reg[4] - pr6_reg[5];
            dot7_reg   <= pr6_reg[6] + pr6_reg[7] + pr6_reg[8];
        end
    end

    // ---------------- stage 8: back to Q2.30
    logic          v8_reg;
    logic          dg8_reg;
    varm_pkg::cq_t c8_reg [3];
    varm_pkg::cq_t cos8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg8_reg <= dg7_reg;
            for (int i = 0; i < 3; i++) begin
                c8_reg[i] <= CW'(varm_pkg::rnd_shift(cr7_reg[i], varm_pkg::UNIT_BITS));
            end
            cos8_reg <= CW'(varm_pkg::rnd_shift(dot7_reg, varm_pkg::UNIT_BITS));
        end
    end

    // ---------------- stage 9: 1+cos, outer products of the cross vector
    logic               v9_reg;
    logic               dg9_reg;
    logic [CW-1:0]      d9_reg;
    logic signed [63:0] cc9_reg [6];
    varm_pkg::cq_t      c9_reg [3];
    varm_pkg::cq_t      cos9_reg;
    varm_pkg::cq_t      d8;

    assign d8 = cos8_reg + varm_pkg::ONE_Q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (en) begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg9_reg    <= dg8_reg || (d8 <= 0);
            d9_reg     <= d8;
            cc9_reg[0] <= 64'(varm_pkg::mul34(c8_reg[0], c8_reg[0]));
            cc9_reg[1] <= 64'(varm_pkg::mul34(c8_reg[0], c8_reg[1]));
            cc9_reg[2] <= 64'(varm_pkg::mul34(c8_reg[0], c8_reg[2]));
            cc9_reg[3] <= 64'(varm_pkg::mul34(c8_reg[1], c8_reg[1]));
            cc9_reg[4] <= 64'(varm_pkg::mul34(c8_reg[1], c8_reg[2]));
            cc9_reg[5] <= 64'(varm_pkg::mul34(c8_reg[2], c8_reg[2]));
            c9_reg     <= c8_reg;
            cos9_reg   <= cos8_reg;
        end
    end

    // ---------------- stage 10: rounded-division numerators
    logic          v10_reg;
    logic          dg10_reg;
    logic [62:0]   num10_reg [6];
    logic          sg10_reg  [6];
    logic [CW-1:0] d10_reg;
    varm_pkg::cq_t c10_reg [3];
    varm_pkg::cq_t cos10_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v10_reg <= 1'b0;
        end else if (en) begin
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg10_reg  <= dg9_reg;
            d10_reg   <= d9_reg;
            c10_reg   <= c9_reg;
            cos10_reg <= cos9_reg;
            for (int i = 0; i < 6; i++) begin
                num10_reg[i] <= 63'(varm_pkg::abs64(cc9_reg[i])) + 63'(d9_reg >> 1);
                sg10_reg[i]  <= cc9_reg[i][63];
            end
        end
    end

    // ---------------- quadratic terms c_i*c_j/(1+cos)
    logic [5:0][62:0]   num2;
    logic [5:0][CW-1:0] den2;
    logic [SB2_W-1:0]   sb2_in, sb2_out;
    logic               dv2_valid;
    logic [5:0][varm_pkg::RQ_QW-1:0] q2;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            num2[i]   = num10_reg[i];
            den2[i]   = d10_reg;
            sb2_in[i] = sg10_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            sb2_in[6+CW*i +: CW] = c10_reg[i];
        end
        sb2_in[6+3*CW +: CW] = cos10_reg;
        sb2_in[SB2_W-1]      = dg10_reg;
    end

    varm_div #(.LANES(6), .NW(63), .DW(CW), .QW(varm_pkg::RQ_QW), .SW(SB2_W)) u_div_quad (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v10_reg),
        .num      (num2),
        .den      (den2),
        .sb_in    (sb2_in),
        .out_valid(dv2_valid),
        .quo      (q2),
        .sb_out   (sb2_out)
    );

    // ---------------- stage 11: signed quotients
    logic                  v11_reg;
    logic                  dg11_reg;
    logic signed [QSW-1:0] qs11_reg [6];
    varm_pkg::cq_t         c11_reg [3];
    varm_pkg::cq_t         cos11_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v11_reg <= 1'b0;
        end else if (en) begin
            v11_reg <= dv2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg11_reg <= sb2_out[SB2_W-1];
            for (int i = 0; i < 6; i++) begin
                qs11_reg[i] <= sb2_out[i] ? -$signed({1'b0, q2[i]}) : $signed({1'b0, q2[i]});
            end
            for (int i = 0; i < 3; i++) begin
                c11_reg[i] <= sb2_out[6+CW*i +: CW];
            end
            cos11_reg <= sb2_out[6+3*CW +: CW];
        end
    end

    // ---------------- stage 12: Rodrigues entries in Q2.30
    logic                 v12_reg;
    logic                 dg12_reg;
    logic signed [RW-1:0] r12_reg [9];
    logic signed [RW-1:0] term [9];
    logic signed [RW-1:0] quad [9];

    always_comb begin
        term[0] = RW'(cos11_reg);   quad[0] = RW'(qs11_reg[0]);
        term[1] = -RW'(c11_reg[2]); quad[1] = RW'(qs11_reg[1]);
        term[2] = RW'(c11_reg[1]);  quad[2] = RW'(qs11_reg[2]);
        term[3] = RW'(c11_reg[2]);  quad[3] = RW'(qs11_reg[1]);
        term[4] = RW'(cos11_reg);   quad[4] = RW'(qs11_reg[3]);
        term[5] = -RW'(c11_reg[0]); quad[5] = RW'(qs11_reg[4]);
        term[6] = -RW'(c11_reg[1]); quad[6] = RW'(qs11_reg[2]);
        term[7] = RW'(c11_reg[0]);  quad[7] = RW'(qs11_reg[4]);
        term[8] = RW'(cos11_reg);   quad[8] = RW'(qs11_reg[5]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v12_reg <= 1'b0;
        end else if (en) begin
            v12_reg <= v11_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg12_reg <= dg11_reg;
            for (int i = 0; i < 9; i++) begin
                r12_reg[i] <= term[i] + quad[i];
            end
        end
    end

    // ---------------- stage 13: round to the output format, saturate, identity
    logic                 v13_reg;
    logic                 dg13_reg;
    varm_pkg::entry_t     m13_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v13_reg <= 1'b0;
        end else if (en) begin
            v13_reg <= v12_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dg13_reg <= dg12_reg;
            for (int i = 0; i < 9; i++) begin
                if (dg12_reg) begin
                    m13_reg[i] <= (i % 4 == 0) ? DIAG : '0;
                end else begin
                    m13_reg[i] <= varm_pkg::sat_out(
                        varm_pkg::rnd_shift(64'(r12_reg[i]), SH));
                end
            end
        end
    end

    // ---------------- output register and skid stage
    logic [OB_W-1:0] ob_in, ob_out;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            ob_in[18*i +: 18] = m13_reg[i];
        end
        ob_in[OB_W-1] = dg13_reg;
    end

    varm_outbuf #(.DATA_W(OB_W)) u_outbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(v13_reg),
        .in_data (ob_in),
        .in_ready(en),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_data  (ob_out)
    );

    assign m_tdata = {6'b0, ob_out[OB_W-2:0]};
    assign m_tuser = ob_out[OB_W-1];

    // A degenerate result carries the identity matrix.
    `VARM_ASSERT_IMP(a_degen_identity, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[17:0] == 18'(DIAG) && m_tdata[35:18] == 18'd0 && m_tdata[89:72] == 18'(DIAG))
    // Input is held off only while a finished result waits.
    `VARM_ASSERT_IMP(a_stall_has_result, aclk, aresetn, !s_tready, m_tvalid)
    // A frozen pipeline keeps its last-stage item.
    `VARM_ASSERT_NXT(a_stall_holds_tail, aclk, aresetn, !en && v13_reg, v13_reg)

endmodule

@@ test/vector_align_rotation_matrix_checker.sv @@
module vector_align_rotation_matrix_checker #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    input  logic [0:0]   m_tuser,
    output int           error_count,
    output int           pending_count
);

    typedef struct packed {
        varm_pkg::entry_t [8:0] entry;
        logic                   degenerate;
    } rotation_t;

    rotation_t rotation_queue[$];
    int        errors_seen = 0;
    int        queued_items = 0;

    assign error_count   = errors_seen;
    assign pending_count = queued_items;

    function automatic longint round_shift(longint v, int sh);
        longint mag;
        mag = v < 0 ? -v : v;
        if (sh > 0) mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint mag;
        mag = n < 0 ? -n : n;
        mag = (mag + d / 2) / d;
        return n < 0 ? -mag : mag;
    endfunction

    function automatic longint int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic void to_unit(longint v[3], longint nrm, ref longint u[3]);
        logic [63:0] mag;
        for (int i = 0; i < 3; i++) begin
            mag = v[i] < 0 ? -v[i] : v[i];
            mag = ((mag << varm_pkg::UNIT_BITS) + nrm / 2) / nrm;
            u[i] = v[i] < 0 ? -longint'(mag) : longint'(mag);
        end
    endfunction

    function automatic varm_pkg::entry_t clamp_entry(longint q30);
        longint v;
        v = round_shift(q30, varm_pkg::UNIT_BITS - OUT_FRAC_BITS);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return varm_pkg::entry_t'(v);
    endfunction

    function automatic rotation_t predict_rotation(logic [191:0] pair);
        longint a[3], b[3], u[3], w[3], c[3], r[9];
        longint na, nb, cosv, d;
        logic [63:0] sa, sb;
        logic degen;
        rotation_t res;
        sa = 0;
        sb = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(varm_pkg::comp_t'(pair[32*i +: 32]));
            b[i] = longint'(varm_pkg::comp_t'(pair[32*(i+3) +: 32]));
            sa += a[i] * a[i];
            sb += b[i] * b[i];
        end
        na = int_sqrt(sa);
        nb = int_sqrt(sb);
        degen = (na == 0) || (nb == 0) ||
                (a[1]*b[2] == a[2]*b[1] && a[2]*b[0] == a[0]*b[2] &&
                 a[0]*b[1] == a[1]*b[0]);
        if (!degen) begin
            to_unit(a, na, u);
            to_unit(b, nb, w);
            c[0] = round_shift(u[1]*w[2] - u[2]*w[1], varm_pkg::UNIT_BITS);
            c[1] = round_shift(u[2]*w[0] - u[0]*w[2], varm_pkg::UNIT_BITS);
            c[2] = round_shift(u[0]*w[1] - u[1]*w[0], varm_pkg::UNIT_BITS);
            cosv = round_shift(u[0]*w[0] + u[1]*w[1] + u[2]*w[2], varm_pkg::UNIT_BITS);
            d = (64'sd1 <<< varm_pkg::UNIT_BITS) + cosv;
            if (d <= 0) degen = 1'b1;
        end
        if (degen) begin
            for (int i = 0; i < 9; i++) begin
                r[i] = (i % 4 == 0) ? (64'sd1 <<< varm_pkg::UNIT_BITS) : 0;
            end
        end else begin
            r[0] = cosv  + round_div(c[0]*c[0], d);
            r[1] = -c[2] + round_div(c[0]*c[1], d);
            r[2] = c[1]  + round_div(c[0]*c[2], d);
            r[3] = c[2]  + round_div(c[0]*c[1], d);
            r[4] = cosv  + round_div(c[1]*c[1], d);
            r[5] = -c[0] + round_div(c[1]*c[2], d);
            r[6] = -c[1] + round_div(c[0]*c[2], d);
            r[7] = c[0]  + round_div(c[1]*c[2], d);
            r[8] = cosv  + round_div(c[2]*c[2], d);
        end
        for (int i = 0; i < 9; i++) res.entry[i] = clamp_entry(r[i]);
        res.degenerate = degen;
        return res;
    endfunction

    always @(posedge aclk) begin
        rotation_t want;
        varm_pkg::entry_t got;
        if (aresetn && s_tvalid && s_tready) begin
            rotation_queue.insert(rotation_queue.size(), predict_rotation(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (rotation_queue.size() == 0) begin
                $error("unexpected result item %h", m_tdata);
                errors_seen++;
            end else begin
                want = rotation_queue.pop_front();
                for (int i = 0; i < 9; i++) begin
                    got = m_tdata[18*i +: 18];
                    if (got !== want.entry[i]) begin
                        $error("m%0d%0d expected %0d actual %0d", i / 3, i % 3,
                               want.entry[i], got);
                        errors_seen++;
                    end
                end
                if (m_tuser[0] !== want.degenerate) begin
                    $error("degenerate expected %0b actual %0b", want.degenerate, m_tuser[0]);
                    errors_seen++;
                end
            end
        end
        queued_items = rotation_queue.size();
    end
endmodule

@@ test/tb_vector_align_rotation_matrix_top.sv @@
module tb_vector_align_rotation_matrix_top;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // first_x, first_y, first_z, second_x, second_y, second_z
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;   // m00 .. m22, zero pad
    logic [0:0]   m_tuser;   // degenerate
    int           error_count;
    int           pending_count;

    vector_align_rotation_matrix_top dut (.*);

    vector_align_rotation_matrix_checker checker_inst (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Pick a component: mostly random, sometimes an extreme or a small value.
    function automatic varm_pkg::comp_t pick_component();
        case ($urandom_range(0, 7))
            0: return varm_pkg::comp_t'(32'h8000_0000);
            1: return varm_pkg::comp_t'(32'h7fff_ffff);
            2: return varm_pkg::comp_t'(0);
            3: return varm_pkg::comp_t'($signed($urandom_range(0, 8192)) - 4096);
            default: return varm_pkg::comp_t'($urandom);
        endcase
    endfunction

    // Send one vector pair after a random gap; hold until it is taken.
    task automatic send_pair(varm_pkg::comp_t ax, varm_pkg::comp_t ay, varm_pkg::comp_t az,
                             varm_pkg::comp_t bx, varm_pkg::comp_t by, varm_pkg::comp_t bz);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bz, by, bx, az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random_pair();
        varm_pkg::comp_t a[3];
        varm_pkg::comp_t b[3];
        int k;
        for (int i = 0; i < 3; i++) a[i] = pick_component();
        k = $signed($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 9))
            // nearly parallel or antiparallel: scale the first vector, shifted right by 3, by a factor from -3 to 3
            0: for (int i = 0; i < 3; i++) b[i] = varm_pkg::comp_t'((a[i] >>> 3) * k);
            // nearly antiparallel: halve and negate, then nudge one component
            1: begin
                for (int i = 0; i < 3; i++) b[i] = varm_pkg::comp_t'(-(a[i] >>> 1));
                b[$urandom_range(0, 2)] += varm_pkg::comp_t'($urandom_range(1, 3));
            end
            default: for (int i = 0; i < 3; i++) b[i] = pick_component();
        endcase
        send_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
    endtask

    // Before every item, hold m_tready low for a randomly drawn wait on the result side.
    initial begin
        int wait_cycles;
        m_tready = 1'b0;
        forever begin
            wait_cycles = $urandom_range(0, 5);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero vectors, extremes, parallel, antiparallel, right angles.
        send_pair(0, 0, 0, 32'sd65536, 0, 0);
        send_pair(32'sd65536, 0, 0, 0, 0, 0);
        send_pair(32'sd65536, 0, 0, 32'sd131072, 0, 0);
        send_pair(32'sd65536, 0, 0, -32'sd65536, 0, 0);
        send_pair(32'sd65536, 0, 0, 0, 32'sd65536, 0);
        send_pair(0, 32'sd65536, 0, 0, 0, 32'sd65536);
        send_pair(0, 0, 32'sd65536, 32'sd65536, 0, 0);
        send_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_pair(32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 1, 0);
        send_pair(32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 0);
        send_pair(1, 0, 0, -1, 1, 0);
        send_pair(1, 2, 3, -2, -4, -6);
        send_pair(32'sd1000000, 0, 0, -32'sd1000000, 1, 0);
        send_pair(-1, -1, -1, 1, 1, 1);
        send_pair(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1, -1, 0);
        send_pair(32'sd65536, 32'sd65536, 0, 0, 32'sd65536, 32'sd65536);

        repeat (1750) send_random_pair();
        s_tvalid <= 1'b0;

        // Drain, then let the pipeline settle.
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
